// ----- design/gim_pkg.sv -----
// Shared types, codes and constants for the gamepad input mapper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gim_pkg;

  localparam int KEY_COUNT_DEF    = 12;
  localparam int STATUS_WIDTH_DEF = 32;

  // Keys that have a bit position field in the shift registers.
  localparam int KEYS_MAPPED = 12;
  localparam int POS_W       = 5;
  localparam int DIR_COUNT   = 4;

  localparam int DZ_W   = 15;
  localparam int LVL_W  = 16;
  localparam int DIV_STEPS = 15;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [LVL_W-1:0] LEVEL_MAX = 16'sh7FFF;
  localparam logic signed [LVL_W-1:0] LEVEL_MIN = 16'sh8000;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Event codes.
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_AXIS    = 2'd2;

  // Analog modes.
  localparam logic [1:0] MODE_DIGITAL = 2'd1;
  localparam logic [1:0] MODE_REAL    = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_KEY_ENABLE     = 3'd0;
  localparam logic [2:0] REG_KEY_SHIFT_LOW  = 3'd1;
  localparam logic [2:0] REG_KEY_SHIFT_HIGH = 3'd2;
  localparam logic [2:0] REG_ANALOG_ENABLE  = 3'd3;
  localparam logic [2:0] REG_ANALOG_SHIFT   = 3'd4;
  localparam logic [2:0] REG_ANALOG_MODE    = 3'd5;
  localparam logic [2:0] REG_DZ_MIN         = 3'd6;
  localparam logic [2:0] REG_DZ_MAX         = 3'd7;

  typedef struct packed {
    logic [11:0]     key_enable;
    logic [29:0]     key_shift_low;
    logic [29:0]     key_shift_high;
    logic [3:0]      analog_enable;
    logic [19:0]     analog_shift;
    logic [1:0]      analog_mode;
    logic [DZ_W-1:0] dz_min;
    logic [DZ_W-1:0] dz_max;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_sts_t;

  // One-hot mask for a status bit position; positions past the status
  // width fall off when the caller truncates the result.
  function automatic logic [31:0] bit_at(input logic [POS_W-1:0] pos);
    return 32'd1 << pos;
  endfunction

endpackage

`default_nettype wire

// ----- design/gim_cfg.sv -----
// Configuration register file with an APB-style write and read port.
// Depends on gim_pkg for the register layout and index codes.
`default_nettype none

module gim_cfg import gim_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{dz_max: DZ_W'(32767), default: '0};
    end else if (wr_en) begin
      case (reg_index)
        REG_KEY_ENABLE:     cfg.key_enable     <= pwdata[11:0];
        REG_KEY_SHIFT_LOW:  cfg.key_shift_low  <= pwdata[29:0];
        REG_KEY_SHIFT_HIGH: cfg.key_shift_high <= pwdata[29:0];
        REG_ANALOG_ENABLE:  cfg.analog_enable  <= pwdata[3:0];
        REG_ANALOG_SHIFT:   cfg.analog_shift   <= pwdata[19:0];
        REG_ANALOG_MODE:    cfg.analog_mode    <= pwdata[1:0];
        REG_DZ_MIN:         cfg.dz_min         <= pwdata[DZ_W-1:0];
        REG_DZ_MAX:         cfg.dz_max         <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_KEY_ENABLE:     prdata = DATA_W'(cfg.key_enable);
      REG_KEY_SHIFT_LOW:  prdata = DATA_W'(cfg.key_shift_low);
      REG_KEY_SHIFT_HIGH: prdata = DATA_W'(cfg.key_shift_high);
      REG_ANALOG_ENABLE:  prdata = DATA_W'(cfg.analog_enable);
      REG_ANALOG_SHIFT:   prdata = DATA_W'(cfg.analog_shift);
      REG_ANALOG_MODE:    prdata = DATA_W'(cfg.analog_mode);
      REG_DZ_MIN:         prdata = DATA_W'(cfg.dz_min);
      REG_DZ_MAX:         prdata = DATA_W'(cfg.dz_max);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/gim_dp.sv -----
// Datapath: captured event, button and level state, and the restoring
// divider that normalizes an axis reading. Depends on gim_pkg.
`default_nettype none

module gim_dp import gim_pkg::*; #(
  parameter int KEY_COUNT    = KEY_COUNT_DEF,
  parameter int STATUS_WIDTH = STATUS_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire dp_cmd_t                 cmd,
  output dp_sts_t                      sts,
  input  wire logic [1:0]              action,
  input  wire logic [3:0]              key_index,
  input  wire logic                    axis_select,
  input  wire logic signed [LVL_W-1:0] axis_value,
  output logic [STATUS_WIDTH-1:0]      button_word,
  output logic signed [LVL_W-1:0]      level_x,
  output logic signed [LVL_W-1:0]      level_y
);

  // Captured event.
  logic [1:0]              act_q;
  logic [3:0]              key_q;
  logic                    axis_q;
  logic signed [LVL_W-1:0] value_q;

  // Divider.
  logic [DZ_W-1:0] rem;
  logic [DZ_W-1:0] quot;
  logic [DZ_W-1:0] delta;
  logic [DZ_W:0]   rem_shift;
  logic            rem_ge;

  logic              neg;
  logic [LVL_W-1:0]  mag_abs;
  logic              beyond_min;
  logic              at_max;
  logic [DZ_W-1:0]   mag;
  logic              key_ok;
  logic [3:0]        key_sel;
  logic [POS_W-1:0]  key_pos [KEYS_MAPPED];
  logic [31:0]       key_bit32;
  logic [31:0]       dir_bit32 [DIR_COUNT];
  logic [STATUS_WIDTH-1:0] key_mask;
  logic [STATUS_WIDTH-1:0] dir_mask [DIR_COUNT];
  logic [STATUS_WIDTH-1:0] lo_mask;
  logic [STATUS_WIDTH-1:0] hi_mask;
  logic [STATUS_WIDTH-1:0] set_mask;
  logic [STATUS_WIDTH-1:0] clr_mask;
  logic [STATUS_WIDTH-1:0] status_next;
  logic signed [LVL_W-1:0] level_new;
  logic                    real_axis;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_q   <= action;
      key_q   <= key_index;
      axis_q  <= axis_select;
      value_q <= axis_value;
    end
  end

  assign neg        = value_q[LVL_W-1];
  assign mag_abs    = neg ? LVL_W'(-value_q) : LVL_W'(value_q);
  assign beyond_min = mag_abs > {1'b0, cfg.dz_min};
  assign at_max     = mag_abs >= {1'b0, cfg.dz_max};
  assign mag        = DZ_W'(mag_abs - {1'b0, cfg.dz_min});
  assign real_axis  = (act_q == ACT_AXIS) && (cfg.analog_mode == MODE_REAL);

  assign sts.need_div = real_axis && beyond_min && !at_max;

  // Restoring division: one quotient bit per step, mag * 2^15 / delta.
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = rem_shift >= {1'b0, delta};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem   <= mag;
      delta <= DZ_W'(cfg.dz_max - cfg.dz_min);
      quot  <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? DZ_W'(rem_shift - {1'b0, delta}) : rem_shift[DZ_W-1:0];
      quot <= {quot[DZ_W-2:0], rem_ge};
    end
  end

  // Key mask.
  always_comb begin
    for (int k = 0; k < KEYS_MAPPED; k++) begin
      if (k < 6) key_pos[k] = cfg.key_shift_low[POS_W*k +: POS_W];
      else       key_pos[k] = cfg.key_shift_high[POS_W*(k-6) +: POS_W];
    end
  end

  assign key_ok = ({1'b0, key_q} < 5'(KEY_COUNT)) && ({1'b0, key_q} < 5'(KEYS_MAPPED)) &&
                  cfg.key_enable[key_q[$clog2(KEYS_MAPPED)-1:0]];
  assign key_sel   = key_ok ? key_q : 4'd0;
  assign key_bit32 = bit_at(key_pos[key_sel]);
  assign key_mask  = key_ok ? key_bit32[STATUS_WIDTH-1:0] : '0;

  // Analog direction masks: left, right, up, down.
  always_comb begin
    for (int d = 0; d < DIR_COUNT; d++) begin
      dir_bit32[d] = bit_at(cfg.analog_shift[POS_W*d +: POS_W]);
      dir_mask[d]  = cfg.analog_enable[d] ? dir_bit32[d][STATUS_WIDTH-1:0] : '0;
    end
  end

  assign lo_mask = dir_mask[{axis_q, 1'b0}];
  assign hi_mask = dir_mask[{axis_q, 1'b1}];

  always_comb begin
    set_mask = '0;
    clr_mask = '0;
    case (act_q)
      ACT_PRESS:   set_mask = key_mask;
      ACT_RELEASE: clr_mask = key_mask;
      ACT_AXIS: begin
        if (cfg.analog_mode == MODE_DIGITAL) begin
          if (!beyond_min) clr_mask = lo_mask | hi_mask;
          else if (neg)    set_mask = lo_mask;
          else             set_mask = hi_mask;
        end
      end
      default: ;
    endcase
  end

  assign status_next = (button_word | set_mask) & ~clr_mask;

  always_comb begin
    if (!beyond_min)  level_new = '0;
    else if (at_max)  level_new = neg ? LEVEL_MIN : LEVEL_MAX;
    else if (neg)     level_new = LVL_W'(-$signed({1'b0, quot}));
    else              level_new = $signed({1'b0, quot});
  end

  // The state registers are the output register; they change only on commit or reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      button_word <= '0;
      level_x     <= '0;
      level_y     <= '0;
    end else if (cmd.commit) begin
      button_word <= status_next;
      if (real_axis && !axis_q) level_x <= level_new;
      if (real_axis && axis_q)  level_y <= level_new;
    end
  end

endmodule

`default_nettype wire

// ----- design/gim_ctrl.sv -----
// Controller: sequences capture, evaluation, division and commit of one
// event, and runs both handshakes. Depends on gim_pkg for command types.
`default_nettype none

module gim_ctrl import gim_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_COMMIT
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !(out_valid && out_stall);

  assign cmd.load_in   = (state == ST_IDLE) && in_valid;
  assign cmd.div_start = (state == ST_EVAL) && sts.need_div;
  assign cmd.div_step  = (state == ST_DIV);
  assign cmd.commit    = (state == ST_COMMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_EVAL;
        end
        ST_EVAL: begin
          cnt <= '0;
          state <= sts.need_div ? ST_DIV : ST_COMMIT;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_EVAL))
    else $error("accepted transaction did not enter evaluation");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> (state == ST_DIV) && (cnt == '0))
    else $error("division did not start from step zero");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> (state == ST_DIV) || (state == ST_COMMIT))
    else $error("division left for an unexpected state");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result");

endmodule

`default_nettype wire

// ----- design/gamepad_input_mapper.sv -----
// Gamepad input mapper: one result transaction per event, reporting button word and levels.
// Each accepted event is captured, evaluated and committed to the registered outputs;
// a real-mode axis reading inside the scaling range first goes through the 15-step
// restoring divider. No new event is taken until commit, which waits out an output stall.
// Synchronous reset clears state, levels and registers (dead_zone_max resets to 32767).
`default_nettype none

module gamepad_input_mapper import gim_pkg::*; #(
  parameter int KEY_COUNT    = KEY_COUNT_DEF,
  parameter int STATUS_WIDTH = STATUS_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              action,
  input  wire logic [3:0]              key_index,
  input  wire logic                    axis_select,
  input  wire logic signed [LVL_W-1:0] axis_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [STATUS_WIDTH-1:0]      button_word,
  output logic signed [LVL_W-1:0]      level_x,
  output logic signed [LVL_W-1:0]      level_y,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [DATA_W-1:0]       pwdata,
  output logic      [DATA_W-1:0]       prdata,
  output logic                         pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  gim_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gim_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gim_dp #(
    .KEY_COUNT    (KEY_COUNT),
    .STATUS_WIDTH (STATUS_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .key_index   (key_index),
    .axis_select (axis_select),
    .axis_value  (axis_value),
    .button_word (button_word),
    .level_x     (level_x),
    .level_y     (level_y)
  );

endmodule

`default_nettype wire

// ----- tb/mapper_checker.sv -----
// Checker for the gamepad input mapper: follows register writes and event transactions,
// predicts each result and compares it with what the block returns.
// Depends on gim_pkg for the register layout, event codes and level limits.
`timescale 1ns / 1ps

module mapper_checker import gim_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              action,
  input  logic [3:0]              key_index,
  input  logic                    axis_select,
  input  logic signed [LVL_W-1:0] axis_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [31:0]             button_word,
  input  logic signed [LVL_W-1:0] level_x,
  input  logic signed [LVL_W-1:0] level_y,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output int                      mismatches,
  output int                      pending
);

  localparam longint FULL_SCALE = 32768;

  typedef struct packed {
    logic [31:0]             buttons;
    logic signed [LVL_W-1:0] lx;
    logic signed [LVL_W-1:0] ly;
  } mapper_report_t;

  mapper_report_t          report_q[$];
  cfg_t                    regs;
  logic [31:0]             buttons_now;
  logic signed [LVL_W-1:0] x_now;
  logic signed [LVL_W-1:0] y_now;
  int                      bad_count;

  function automatic logic [31:0] key_bit(input cfg_t c, input logic [3:0] k);
    logic [POS_W-1:0] pos;
    if (k < 6) pos = c.key_shift_low[POS_W*k +: POS_W];
    else pos = c.key_shift_high[POS_W*(k-6) +: POS_W];
    return 32'd1 << pos;
  endfunction

  // Directions: 0 left, 1 right, 2 up, 3 down.
  function automatic logic [31:0] dir_bit(input cfg_t c, input int dir);
    if (!c.analog_enable[dir]) return 32'd0;
    return 32'd1 << c.analog_shift[POS_W*dir +: POS_W];
  endfunction

  function automatic logic signed [LVL_W-1:0] scaled_level(input cfg_t c,
                                                           input logic signed [LVL_W-1:0] v);
    int     mag;
    int     lo;
    int     hi;
    longint quo;
    mag = (v < 0) ? -int'(v) : int'(v);
    lo  = int'(c.dz_min);
    hi  = int'(c.dz_max);
    if (mag <= lo) return '0;
    // An inverted dead zone lands here for every reading beyond the minimum.
    if (mag >= hi) return (v < 0) ? LEVEL_MIN : LEVEL_MAX;
    quo = (longint'(mag - lo) * FULL_SCALE) / longint'(hi - lo);
    if (quo > 32767) quo = 32767;
    return (v < 0) ? LVL_W'(-quo) : LVL_W'(quo);
  endfunction

  always @(posedge clk) begin
    mapper_report_t got;
    mapper_report_t want;
    logic [31:0]    m;
    int             lane;
    int             reading;
    int             lim;
    if (rst) begin
      report_q.delete();
      regs        = '0;
      regs.dz_max = '1;
      buttons_now = '0;
      x_now       = '0;
      y_now       = '0;
      bad_count   = 0;
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_KEY_ENABLE:     regs.key_enable     = pwdata[11:0];
          REG_KEY_SHIFT_LOW:  regs.key_shift_low  = pwdata[29:0];
          REG_KEY_SHIFT_HIGH: regs.key_shift_high = pwdata[29:0];
          REG_ANALOG_ENABLE:  regs.analog_enable  = pwdata[3:0];
          REG_ANALOG_SHIFT:   regs.analog_shift   = pwdata[19:0];
          REG_ANALOG_MODE:    regs.analog_mode    = pwdata[1:0];
          REG_DZ_MIN:         regs.dz_min         = pwdata[DZ_W-1:0];
          REG_DZ_MAX:         regs.dz_max         = pwdata[DZ_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (action == ACT_PRESS || action == ACT_RELEASE) begin
          if (key_index < KEY_COUNT_DEF && key_index < KEYS_MAPPED) begin
            if (regs.key_enable[key_index]) begin
              m = key_bit(regs, key_index);
              if (action == ACT_PRESS) buttons_now = buttons_now | m;
              else buttons_now = buttons_now & ~m;
            end
          end
        end else if (action == ACT_AXIS) begin
          lane    = axis_select ? 2 : 0;
          reading = int'(axis_value);
          lim     = int'(regs.dz_min);
          if (regs.analog_mode == MODE_DIGITAL) begin
            if (reading < -lim) buttons_now = buttons_now | dir_bit(regs, lane);
            else if (reading > lim) buttons_now = buttons_now | dir_bit(regs, lane + 1);
            else buttons_now = buttons_now & ~(dir_bit(regs, lane) | dir_bit(regs, lane + 1));
          end else if (regs.analog_mode == MODE_REAL) begin
            if (axis_select) y_now = scaled_level(regs, axis_value);
            else x_now = scaled_level(regs, axis_value);
          end
        end
        report_q.push_back('{buttons: buttons_now, lx: x_now, ly: y_now});
      end

      if (out_valid && !out_stall) begin
        got = '{buttons: button_word, lx: level_x, ly: level_y};
        if (report_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result with nothing expected: buttons %h x %0d y %0d",
                     $realtime, got.buttons, got.lx, got.ly);
        end else begin
          want = report_q.pop_front();
          if (got.buttons !== want.buttons || got.lx !== want.lx || got.ly !== want.ly) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: mismatch: buttons exp %h got %h, x exp %0d got %0d, y exp %0d got %0d",
                       $realtime, want.buttons, got.buttons, want.lx, got.lx, want.ly, got.ly);
          end
        end
      end

      mismatches <= bad_count;
      pending    <= report_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the gamepad input mapper testbench: clock, reset, register writes and event
// stimulus with random pacing. Depends on gim_pkg, the block and mapper_checker.
`timescale 1ns / 1ps

module testbench;
  import gim_pkg::*;

  localparam logic [1:0] ACT_NONE      = 2'd3;
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam int         PHASES        = 9;
  localparam int         PHASE_ITEMS   = 195;
  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         SETTLE        = 24;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              action = ACT_PRESS;
  logic [3:0]              key_index = '0;
  logic                    axis_select = 1'b0;
  logic signed [LVL_W-1:0] axis_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [31:0]             button_word;
  logic signed [LVL_W-1:0] level_x;
  logic signed [LVL_W-1:0] level_y;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int mismatches;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int cur_min = 0;
  int cur_max = 32767;

  always #5 clk = ~clk;

  gamepad_input_mapper u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_index(key_index), .axis_select(axis_select),
    .axis_value(axis_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .button_word(button_word), .level_x(level_x), .level_y(level_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mapper_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_index(key_index), .axis_select(axis_select),
    .axis_value(axis_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .button_word(button_word), .level_x(level_x), .level_y(level_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver switches between stall styles at random intervals.
  int stall_style = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 3);
        stall_left  = $urandom_range(20, 300);
      end else begin
        stall_left--;
      end
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every expected result drain, then idles for a settling period.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send(input logic [1:0] act, input logic [3:0] key, input logic ax,
                      input int val);
    in_valid    <= 1'b1;
    action      <= act;
    key_index   <= key;
    axis_select <= ax;
    axis_value  <= LVL_W'(val);
    do @(posedge clk); while (in_stall);
    pace();
  endtask

  function automatic int pick_reading();
    int v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      2: v = cur_min + $urandom_range(0, 2) - 1;
      3: v = cur_max + $urandom_range(0, 2) - 1;
      4: v = 0;
      default: v = $urandom_range(0, 65535) - 32768;
    endcase
    if (v > 0 && $urandom_range(0, 1) == 1) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic send_random();
    int          r;
    logic [1:0]  act;
    logic [3:0]  key;
    r = $urandom_range(0, 99);
    if (r < 25) act = ACT_PRESS;
    else if (r < 50) act = ACT_RELEASE;
    else if (r < 95) act = ACT_AXIS;
    else act = ACT_NONE;
    key = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
    send(act, key, 1'($urandom_range(0, 1)), pick_reading());
  endtask

  task automatic load_settings(input logic [1:0] mode, input int mn, input int mx,
                               input logic [11:0] ken, input logic [3:0] aen,
                               input logic [29:0] shl, input logic [29:0] shh,
                               input logic [19:0] ash);
    write_reg(REG_KEY_ENABLE, 32'(ken));
    write_reg(REG_KEY_SHIFT_LOW, 32'(shl));
    write_reg(REG_KEY_SHIFT_HIGH, 32'(shh));
    write_reg(REG_ANALOG_ENABLE, 32'(aen));
    write_reg(REG_ANALOG_SHIFT, 32'(ash));
    write_reg(REG_ANALOG_MODE, 32'(mode));
    write_reg(REG_DZ_MIN, 32'(mn));
    write_reg(REG_DZ_MAX, 32'(mx));
    cur_min = mn;
    cur_max = mx;
  endtask

  initial begin
    logic [1:0]  mode;
    logic [11:0] ken;
    logic [3:0]  aen;
    logic [29:0] shl;
    logic [29:0] shh;
    logic [19:0] ash;
    int          mn;
    int          mx;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Key 3 disabled, key 0 at bit 0, key 5 at bit 31; up direction disabled.
    load_settings(MODE_DIGITAL, 1000, 30000, 12'hFF7, 4'b1011,
                  {5'd31, 5'd9, 5'd7, 5'd12, 5'd3, 5'd0},
                  {5'd30, 5'd22, 5'd14, 5'd6, 5'd1, 5'd18},
                  {5'd20, 5'd21, 5'd30, 5'd31});
    send(ACT_PRESS, 4'd0, 1'b0, 0);
    send(ACT_PRESS, 4'd5, 1'b0, 0);
    send(ACT_PRESS, 4'd11, 1'b0, 0);
    send(ACT_PRESS, 4'd3, 1'b0, 0);
    send(ACT_PRESS, 4'd12, 1'b0, 0);
    send(ACT_PRESS, 4'd15, 1'b1, -1);
    send(ACT_RELEASE, 4'd5, 1'b0, 0);
    send(ACT_NONE, 4'd0, 1'b1, -32768);
    send(ACT_AXIS, 4'd0, 1'b0, -32768);
    // The opposite direction bit stays set while the other one is set.
    send(ACT_AXIS, 4'd0, 1'b0, 32767);
    send(ACT_AXIS, 4'd0, 1'b0, 1000);
    send(ACT_AXIS, 4'd0, 1'b1, -5000);
    send(ACT_AXIS, 4'd0, 1'b1, 5000);
    send(ACT_AXIS, 4'd0, 1'b1, 0);
    send(ACT_RELEASE, 4'd0, 1'b0, 0);

    wait_idle();
    write_reg(REG_ANALOG_MODE, 32'(MODE_REAL));
    send(ACT_AXIS, 4'd0, 1'b0, 32767);
    send(ACT_AXIS, 4'd0, 1'b0, -32768);
    send(ACT_AXIS, 4'd0, 1'b1, 1001);
    send(ACT_AXIS, 4'd0, 1'b1, -29999);
    send(ACT_AXIS, 4'd0, 1'b0, 1000);

    // Dead zone maximum below the minimum saturates anything beyond the minimum.
    wait_idle();
    write_reg(REG_DZ_MAX, 32'd500);
    send(ACT_AXIS, 4'd0, 1'b0, -1001);
    send(ACT_AXIS, 4'd0, 1'b1, 999);

    wait_idle();
    write_reg(REG_ANALOG_MODE, 32'(MODE_RESERVED));
    send(ACT_AXIS, 4'd0, 1'b0, -32768);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      ken = 12'($urandom | $urandom);
      aen = 4'($urandom | $urandom);
      shl = 30'($urandom);
      shh = 30'($urandom);
      ash = 20'($urandom);
      mn  = $urandom_range(0, 20000);
      mx  = $urandom_range(0, 32767);
      case (ph)
        0: mode = MODE_DIGITAL;
        1: begin
          mode = MODE_REAL;
          mn   = 0;
          mx   = 32767;
          ken  = '1;
          aen  = '1;
          shl  = '1;
          shh  = '1;
          ash  = '1;
        end
        2: begin
          mode = MODE_REAL;
          mn   = $urandom_range(0, 16000);
          mx   = $urandom_range(mn + 1, 32767);
        end
        3: begin
          mode = MODE_REAL;
          mn   = $urandom_range(0, 32767);
          mx   = $urandom_range(0, mn);
        end
        4: begin
          mode = MODE_OFF;
          shl  = '0;
          shh  = '0;
          ash  = '0;
        end
        5: begin
          mode = MODE_RESERVED;
          ken  = '0;
        end
        6: begin
          mode = MODE_DIGITAL;
          mn   = 32767;
          mx   = 32767;
          aen  = '0;
        end
        7: begin
          mode = MODE_DIGITAL;
          mn   = 0;
          mx   = 0;
          aen  = '1;
        end
        default: begin
          mode = MODE_REAL;
          mn   = $urandom_range(0, 32766);
          mx   = mn + 1;
        end
      endcase
      load_settings(mode, mn, mx, ken, aen, shl, shh, ash);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) wait_idle();
        send_random();
      end
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/gim_pkg.sv
design/gim_cfg.sv
design/gim_dp.sv
design/gim_ctrl.sv
design/gamepad_input_mapper.sv
tb/mapper_checker.sv
tb/testbench.sv
